### sv/bsfb_pkg.sv
// Shared types, constants and helpers of the byte stuffing frame builder.
`default_nettype none

package bsfb_pkg;

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_FLAG  = 8'h5E;
    localparam logic [7:0] ESC_ESC   = 8'h5D;

    // Register indexes on the config channel
    localparam int unsigned CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] CFG_SRC_ADDR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DST_ADDR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_CODE = 2'd2;

    // Output slots of one input word, in stream order
    localparam int unsigned NUM_SLOTS = 10;
    localparam int unsigned SLOT_W    = 4;
    typedef logic [SLOT_W-1:0] slot_t;
    localparam slot_t SLOT_OPEN     = 4'd0;
    localparam slot_t SLOT_SRC      = 4'd1;
    localparam slot_t SLOT_SRC_ESC  = 4'd2;
    localparam slot_t SLOT_DST      = 4'd3;
    localparam slot_t SLOT_DST_ESC  = 4'd4;
    localparam slot_t SLOT_DIR      = 4'd5;
    localparam slot_t SLOT_DIR_ESC  = 4'd6;
    localparam slot_t SLOT_DATA     = 4'd7;
    localparam slot_t SLOT_DATA_ESC = 4'd8;
    localparam slot_t SLOT_CLOSE    = 4'd9;

    typedef struct packed {
        logic [7:0] src_addr;
        logic [7:0] dst_addr;
        logic [7:0] dir_code;
    } hdr_cfg_t;

    typedef struct packed {
        logic [7:0] line_byte;
        logic       run_last;
        logic       frame_done;
    } out_word_t;

    function automatic logic needs_esc(input logic [7:0] b);
        return (b == FLAG_BYTE) || (b == ESC_BYTE);
    endfunction

    // First byte sent for b: escape lead or b itself
    function automatic logic [7:0] esc_lead(input logic [7:0] b);
        return needs_esc(b) ? ESC_BYTE : b;
    endfunction

    // Second byte of an escape pair
    function automatic logic [7:0] esc_tail(input logic [7:0] b);
        return (b == FLAG_BYTE) ? ESC_FLAG : ESC_ESC;
    endfunction

endpackage

`default_nettype wire

### sv/bsfb_cfg_regs.sv
// Header configuration registers written through the config channel.
`default_nettype none

module bsfb_cfg_regs
    import bsfb_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]           cfg_data,
    output hdr_cfg_t                  hdr
);

    hdr_cfg_t hdr_reg;
    hdr_cfg_t hdr_next;

    assign cfg_ready = 1'b1;
    assign hdr       = hdr_reg;

    always_comb
    begin
        hdr_next = hdr_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SRC_ADDR: hdr_next.src_addr = cfg_data;
                CFG_DST_ADDR: hdr_next.dst_addr = cfg_data;
                CFG_DIR_CODE: hdr_next.dir_code = cfg_data;
                default:      hdr_next = hdr_reg;  // no register there
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            hdr_reg <= '0;
        else
            hdr_reg <= hdr_next;
    end

endmodule

`default_nettype wire

### sv/bsfb_expander.sv
// Input word register and slot sequencer that turns one word into its bytes.
`default_nettype none

module bsfb_expander
    import bsfb_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       s_tvalid,
    output logic            s_tready,
    input  wire logic [7:0] s_tdata,
    input  wire logic       s_tuser,
    input  wire logic       s_tlast,
    input  wire hdr_cfg_t   hdr,
    input  wire logic       take,
    output logic            word_valid,
    output out_word_t       word
);

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_byte_reg;
    logic       in_start_reg;
    logic       in_finish_reg;
    slot_t      pos_reg, pos_next;

    logic [NUM_SLOTS-1:0] mask;
    slot_t                nxt_slot;
    logic                 has_next;
    logic                 emit;
    logic                 s_accept;

    // Slots that this word produces
    always_comb
    begin
        mask                = '0;
        mask[SLOT_OPEN]     = in_start_reg;
        mask[SLOT_SRC]      = in_start_reg;
        mask[SLOT_SRC_ESC]  = in_start_reg && needs_esc(hdr.src_addr);
        mask[SLOT_DST]      = in_start_reg;
        mask[SLOT_DST_ESC]  = in_start_reg && needs_esc(hdr.dst_addr);
        mask[SLOT_DIR]      = in_start_reg;
        mask[SLOT_DIR_ESC]  = in_start_reg && needs_esc(hdr.dir_code);
        mask[SLOT_DATA]     = 1'b1;
        mask[SLOT_DATA_ESC] = needs_esc(in_byte_reg);
        mask[SLOT_CLOSE]    = in_finish_reg;
    end

    // Lowest active slot above the current one
    always_comb
    begin
        nxt_slot = pos_reg;
        has_next = 1'b0;
        for (int i = NUM_SLOTS - 1; i >= 0; i--)
        begin
            if (mask[i] && (slot_t'(i) > pos_reg))
            begin
                nxt_slot = slot_t'(i);
                has_next = 1'b1;
            end
        end
    end

    always_comb
    begin
        word.run_last   = !has_next;
        word.frame_done = 1'b0;
        unique case (pos_reg)
            SLOT_OPEN:     word.line_byte = FLAG_BYTE;
            SLOT_SRC:      word.line_byte = esc_lead(hdr.src_addr);
            SLOT_SRC_ESC:  word.line_byte = esc_tail(hdr.src_addr);
            SLOT_DST:      word.line_byte = esc_lead(hdr.dst_addr);
            SLOT_DST_ESC:  word.line_byte = esc_tail(hdr.dst_addr);
            SLOT_DIR:      word.line_byte = esc_lead(hdr.dir_code);
            SLOT_DIR_ESC:  word.line_byte = esc_tail(hdr.dir_code);
            SLOT_DATA:     word.line_byte = esc_lead(in_byte_reg);
            SLOT_DATA_ESC: word.line_byte = esc_tail(in_byte_reg);
            SLOT_CLOSE:
            begin
                word.line_byte  = FLAG_BYTE;
                word.frame_done = 1'b1;
            end
            default:       word.line_byte = FLAG_BYTE;  // unused codes
        endcase
    end

    assign word_valid = in_valid_reg;
    assign emit       = in_valid_reg && take;
    assign s_tready   = !in_valid_reg || (take && !has_next);
    assign s_accept   = s_tvalid && s_tready;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        pos_next      = pos_reg;
        if (s_accept)
        begin
            in_valid_next = 1'b1;
            pos_next      = s_tuser ? SLOT_OPEN : SLOT_DATA;
        end
        else if (emit)
        begin
            in_valid_next = has_next;
            pos_next      = nxt_slot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            pos_reg      <= SLOT_DATA;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            pos_reg      <= pos_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            in_byte_reg   <= s_tdata;
            in_start_reg  <= s_tuser;
            in_finish_reg <= s_tlast;
        end
    end

endmodule

`default_nettype wire

### sv/bsfb_out_reg.sv
// Output register holding one line byte toward the master side.
`default_nettype none

module bsfb_out_reg
    import bsfb_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       word_valid,
    input  wire out_word_t  word,
    output logic            take,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,
    output logic            m_tlast,
    output logic            m_tuser
);

    logic      out_valid_reg, out_valid_next;
    out_word_t out_word_reg;

    assign take           = !out_valid_reg || m_tready;
    assign out_valid_next = take ? word_valid : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (take && word_valid)
            out_word_reg <= word;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_word_reg.line_byte;
    assign m_tlast  = out_word_reg.run_last;
    assign m_tuser  = out_word_reg.frame_done;

endmodule

`default_nettype wire

### sv/byte_stuffing_frame_builder_top.sv
// Top level of the byte stuffing frame builder.
//
// Slave side takes payload words: s_tdata is the raw byte, s_tuser marks the
// first byte of a frame, s_tlast the last. Master side gives the line stream
// one byte per word: opening flag 0x7E and three header bytes on a first
// byte, the payload byte, closing flag on a last byte. Header and payload
// bytes are escaped (0x7E -> 7D 5E, 0x7D -> 7D 5D). m_tlast marks the final
// byte caused by one input word, m_tuser marks a closing flag.
// Header bytes come from the config channel (index 0 source, 1 destination,
// 2 direction); cfg_ready is always high, write only while idle.
// The input word is held in the input register, and its first line byte then
// loads the output register, from which it shows on the master side. Each
// input word gives 1 to 10 line bytes, one line byte per cycle while m_tready
// stays high, set by the single output register; the next input word loads in
// the same cycle the last byte of the current one moves out.
// Reset: all header registers clear to 0, both stages empty.
// Stall: a low m_tready holds the output register; the input register
// holds its word and s_tready drops until the stream moves again.
`default_nettype none

module byte_stuffing_frame_builder_top
    import bsfb_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    input  wire logic [7:0]           s_tdata,   // [7:0] payload_byte
    input  wire logic                 s_tuser,   // [0] frame_start
    input  wire logic                 s_tlast,   // frame_finish
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    output logic [7:0]                m_tdata,   // [7:0] line_byte
    output logic                      m_tuser,   // [0] frame_done
    output logic                      m_tlast,   // run_last
    input  wire logic                 cfg_valid,
    output logic                      cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] cfg_index,
    input  wire logic [7:0]           cfg_data
);

    hdr_cfg_t  hdr;
    logic      take;
    logic      word_valid;
    out_word_t word;

    bsfb_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .hdr       (hdr)
    );

    bsfb_expander u_expander (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .s_tlast    (s_tlast),
        .hdr        (hdr),
        .take       (take),
        .word_valid (word_valid),
        .word       (word)
    );

    bsfb_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .word_valid (word_valid),
        .word       (word),
        .take       (take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

`default_nettype wire

### sv/bsfb_checker.sv
// Port-level checks of the frame builder and their bind to the top level.
`default_nettype none

module bsfb_checker
    import bsfb_pkg::*;
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       m_tvalid,
    input wire logic       m_tready,
    input wire logic [7:0] m_tdata,
    input wire logic       m_tlast,
    input wire logic       m_tuser
);

    // Stalled output word holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)
            && $stable(m_tlast) && $stable(m_tuser))
        else $error("output word changed while stalled");

    // Closing flag is a flag and ends the run
    a_close: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser |-> m_tdata == FLAG_BYTE && m_tlast)
        else $error("closing flag malformed");

    // Escape lead always has its second byte after it
    a_esc: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata == ESC_BYTE |-> !m_tlast)
        else $error("escape byte ends a run");

    // A flag that is not closing is an opening flag, header follows
    a_open: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata == FLAG_BYTE && !m_tuser |-> !m_tlast)
        else $error("opening flag ends a run");

endmodule

bind byte_stuffing_frame_builder_top bsfb_checker u_bsfb_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

`default_nettype wire

### tb/sv/tb_byte_stuffing_frame_builder_top.sv
// Self-checking testbench for the byte stuffing frame builder top level.
`timescale 1ns / 1ps

module tb_byte_stuffing_frame_builder_top;
    import bsfb_pkg::*;

    // One payload word as the slave side sees it
    typedef struct {
        logic [7:0] payload;
        logic       start;
        logic       finish;
    } payload_word_t;

    // One pending register write
    typedef struct {
        logic [CFG_IDX_W-1:0] index;
        logic [7:0]           value;
    } reg_write_t;

    localparam int unsigned DRAIN_GUARD = 50000;  // cycles allowed to drain one phase

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [7:0]           s_tdata   = 8'h00;  // [7:0] payload_byte
    logic                 s_tuser   = 1'b0;   // [0] frame_start
    logic                 s_tlast   = 1'b0;   // frame_finish
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [7:0]           m_tdata;            // [7:0] line_byte
    logic                 m_tuser;            // [0] frame_done
    logic                 m_tlast;            // run_last
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_SRC_ADDR;
    logic [7:0]           cfg_data  = 8'h00;

    byte_stuffing_frame_builder_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Stimulus and scoreboard storage
    payload_word_t payload_q[$];     // words waiting to be driven
    reg_write_t    reg_write_q[$];   // register writes waiting to be driven
    out_word_t     line_expect_q[$]; // line bytes predicted, oldest first
    hdr_cfg_t      hdr_shadow = '0;  // header registers as the block should hold them
    int            err_count  = 0;

    // Last predicted byte is held back so run_last can be set on it
    out_word_t     held_line;
    logic          held_valid = 1'b0;

    // Idle pattern state of each side
    int            src_gap    = 0;
    int            src_mode_n = 0;
    logic          src_burst  = 1'b0;
    int            sink_gap    = 0;
    int            sink_mode_n = 0;
    logic          sink_burst  = 1'b0;

    initial
    begin
        forever #10 clk = ~clk;
    end

    // Hard stop, far beyond the slowest legal run
    initial
    begin
        #10_000_000;
        $display("byte_stuffing_frame_builder_top regression: fail");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("ERROR %0t ns: %s got 0x%0h expected 0x%0h", $time, what, got, want);
        err_count++;
    endtask

    // Idle lengths: mostly none or short, now and then long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // ------------------------------------------------------------------
    // Predictor: line bytes for one accepted payload word
    // ------------------------------------------------------------------
    function automatic void emit_line(input logic [7:0] b, input logic done);
        if (held_valid)
            line_expect_q.push_back(held_line);
        held_line.line_byte  = b;
        held_line.run_last   = 1'b0;
        held_line.frame_done = done;
        held_valid           = 1'b1;
    endfunction

    // 0x7E and 0x7D go out as an escape pair, all else as is
    function automatic void emit_stuffed(input logic [7:0] b);
        if (b == FLAG_BYTE)
        begin
            emit_line(ESC_BYTE, 1'b0);
            emit_line(ESC_FLAG, 1'b0);
        end
        else if (b == ESC_BYTE)
        begin
            emit_line(ESC_BYTE, 1'b0);
            emit_line(ESC_ESC, 1'b0);
        end
        else
            emit_line(b, 1'b0);
    endfunction

    function automatic void predict_line_bytes(input logic [7:0] payload,
                                               input logic start, input logic finish);
        if (start)
        begin
            emit_line(FLAG_BYTE, 1'b0);
            emit_stuffed(hdr_shadow.src_addr);
            emit_stuffed(hdr_shadow.dst_addr);
            emit_stuffed(hdr_shadow.dir_code);
        end
        emit_stuffed(payload);
        if (finish)
            emit_line(FLAG_BYTE, 1'b1);
        // close the run: last byte of this word carries run_last
        held_line.run_last = 1'b1;
        line_expect_q.push_back(held_line);
        held_valid = 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Slave-side driver: one word per handshake, random gaps between
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : payload_driver
        payload_word_t nxt;
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                predict_line_bytes(s_tdata, s_tuser, s_tlast);
            if (!s_tvalid || s_tready)
            begin
                if (src_gap > 0)
                begin
                    src_gap--;
                    s_tvalid <= 1'b0;
                end
                else if (payload_q.size() > 0)
                begin
                    nxt = payload_q.pop_front();
                    s_tdata  <= nxt.payload;
                    s_tuser  <= nxt.start;
                    s_tlast  <= nxt.finish;
                    s_tvalid <= 1'b1;
                    // switch between back-to-back stretches and gappy ones
                    if (src_mode_n == 0)
                    begin
                        src_burst  = ($urandom_range(0, 3) == 0);
                        src_mode_n = $urandom_range(10, 40);
                    end
                    else
                        src_mode_n--;
                    src_gap = src_burst ? 0 : pick_gap();
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Register write driver; shadow follows each completed write
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : reg_driver
        reg_write_t wr;
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SRC_ADDR: hdr_shadow.src_addr = cfg_data;
                    CFG_DST_ADDR: hdr_shadow.dst_addr = cfg_data;
                    CFG_DIR_CODE: hdr_shadow.dir_code = cfg_data;
                    default: ;
                endcase
            end
            if (!cfg_valid || cfg_ready)
            begin
                if (reg_write_q.size() > 0)
                begin
                    wr = reg_write_q.pop_front();
                    cfg_index <= wr.index;
                    cfg_data  <= wr.value;
                    cfg_valid <= 1'b1;
                end
                else
                    cfg_valid <= 1'b0;
            end
        end
    end

    // ------------------------------------------------------------------
    // Master-side monitor: compare each line byte, stall at random
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : line_monitor
        out_word_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (line_expect_q.size() == 0)
                    report_mismatch("line byte with nothing pending", m_tdata, 0);
                else
                begin
                    want = line_expect_q.pop_front();
                    if (m_tdata !== want.line_byte)
                        report_mismatch("line_byte", m_tdata, want.line_byte);
                    if (m_tlast !== want.run_last)
                        report_mismatch("run_last", m_tlast, want.run_last);
                    if (m_tuser !== want.frame_done)
                        report_mismatch("frame_done", m_tuser, want.frame_done);
                end
            end
            if (sink_gap > 0)
            begin
                sink_gap--;
                m_tready <= 1'b0;
            end
            else
            begin
                m_tready <= 1'b1;
                if (sink_mode_n == 0)
                begin
                    sink_burst  = ($urandom_range(0, 3) == 0);
                    sink_mode_n = $urandom_range(20, 80);
                end
                else
                    sink_mode_n--;
                sink_gap = sink_burst ? 0 : pick_gap();
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic void add_word(input logic [7:0] payload,
                                     input logic start, input logic finish);
        payload_word_t w;
        w.payload = payload;
        w.start   = start;
        w.finish  = finish;
        payload_q.push_back(w);
    endfunction

    function automatic void set_header(input logic [7:0] src, input logic [7:0] dst,
                                       input logic [7:0] dir);
        reg_write_t wr;
        wr.index = CFG_SRC_ADDR; wr.value = src; reg_write_q.push_back(wr);
        wr.index = CFG_DST_ADDR; wr.value = dst; reg_write_q.push_back(wr);
        wr.index = CFG_DIR_CODE; wr.value = dir; reg_write_q.push_back(wr);
    endfunction

    // Header values lean on the escape bytes and the range ends
    function automatic logic [7:0] pick_header_byte();
        case ($urandom_range(0, 5))
            0: return 8'h00;
            1: return 8'hFF;
            2: return FLAG_BYTE;
            3: return ESC_BYTE;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [7:0] pick_payload();
        case ($urandom_range(0, 9))
            0: return FLAG_BYTE;
            1: return ESC_BYTE;
            2: return ($urandom_range(0, 1) == 1) ? ESC_FLAG : ESC_ESC;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    // Mostly well-formed frames of random length, some loose words
    function automatic void add_random_traffic(input int n_words);
        int count;
        int len;
        count = 0;
        while (count < n_words)
        begin
            if ($urandom_range(0, 9) < 2)
            begin
                add_word(pick_payload(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
                count++;
            end
            else
            begin
                len = $urandom_range(1, 8);
                for (int i = 0; i < len; i++)
                    add_word(pick_payload(), i == 0, i == len - 1);
                count += len;
            end
        end
    endfunction

    // Wait until every word, write and line byte is through
    task automatic wait_idle();
        int guard;
        guard = 0;
        while (!(payload_q.size() == 0 && !s_tvalid && reg_write_q.size() == 0 &&
                 !cfg_valid && line_expect_q.size() == 0) && guard < DRAIN_GUARD)
        begin
            @(posedge clk);
            guard++;
        end
        if (guard >= DRAIN_GUARD)
        begin
            report_mismatch("line bytes never seen, count", 0, line_expect_q.size());
            line_expect_q.delete();
        end
    endtask

    // ------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------
    initial
    begin : test_sequence
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Header registers straight out of reset: one-byte frame
        add_word(8'h00, 1'b1, 1'b1);
        wait_idle();

        // Header full of escape work
        set_header(FLAG_BYTE, ESC_BYTE, 8'hFF);
        wait_idle();
        add_word(FLAG_BYTE, 1'b1, 1'b1);  // longest case for this header: nine line bytes
        add_word(ESC_BYTE,  1'b1, 1'b0);
        add_word(8'hFF,     1'b0, 1'b0);
        add_word(ESC_FLAG,  1'b0, 1'b0);
        add_word(FLAG_BYTE, 1'b0, 1'b1);
        add_word(ESC_BYTE,  1'b0, 1'b0);  // loose byte outside any frame
        add_word(8'h00,     1'b0, 1'b1);  // finish with no frame opened
        add_word(ESC_ESC,   1'b1, 1'b0);
        add_word(8'h80,     1'b0, 1'b1);
        wait_idle();

        set_header(8'h00, 8'hFF, FLAG_BYTE);
        wait_idle();
        add_word(ESC_BYTE,  1'b1, 1'b1);
        add_word(8'h01,     1'b1, 1'b0);
        add_word(FLAG_BYTE, 1'b0, 1'b0);
        add_word(8'hFF,     1'b0, 1'b1);
        wait_idle();

        // Random traffic under several header settings, all-ones first
        for (int ph = 0; ph < 5; ph++)
        begin
            if (ph == 0)
                set_header(8'hFF, 8'hFF, 8'hFF);
            else
                set_header(pick_header_byte(), pick_header_byte(), pick_header_byte());
            wait_idle();
            add_random_traffic(20);
            wait_idle();
        end

        // output register may still be winding down
        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("byte_stuffing_frame_builder_top regression: pass");
        else
            $display("byte_stuffing_frame_builder_top regression: fail");
        $finish;
    end

endmodule
